/* rtl/core/gbg_pkg.sv */
// ----------------------------------------------------------------------------
// gbg_pkg
// Types, constants and the coefficient table shared by the 5x5 gray blur.
// ----------------------------------------------------------------------------
package gbg_pkg;

    localparam int KERNEL_SIZE = 5;
    localparam int HALF_K      = KERNEL_SIZE / 2;
    localparam int COEF_BITS   = 16;
    localparam int LANE_W      = $clog2(KERNEL_SIZE);

    localparam int PIX_W   = 8;
    localparam int ROW_W   = 12;
    localparam int OCOL_W  = 10;
    localparam int OROW_W  = 12;
    localparam int CFGW_W  = 11;
    localparam int CFGH_W  = 13;
    localparam int CFGD_W  = 13;
    localparam int CMP_W   = 13;
    localparam int MAX_ROWS = 4096;

    localparam int ACC_W   = COEF_BITS + PIX_W + 1;

    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Configuration register indexes.
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0] t_col;

    typedef struct packed {
        logic [CFGW_W-1:0] width;
        logic [CFGH_W-1:0] height;
    } t_frame_cfg;

    // One word per accepted pixel: the gray column ending at this pixel,
    // oldest row first, and what the back end needs if a result is due.
    typedef struct packed {
        t_col              col;
        logic              emit;
        logic [OCOL_W-1:0] ccol;
        logic [OROW_W-1:0] crow;
        logic              last;
    } t_qword;

    typedef struct packed {
        logic              not_empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    // Normalized sigma-1 Gaussian weights in Q0.16, by squared distance.
    function automatic logic [COEF_BITS-1:0] coef(input int di, input int dj);
        int d2;
        d2 = (di - HALF_K) * (di - HALF_K) + (dj - HALF_K) * (dj - HALF_K);
        case (d2)
            0:       coef = COEF_BITS'(10624);
            1:       coef = COEF_BITS'(6444);
            2:       coef = COEF_BITS'(3908);
            4:       coef = COEF_BITS'(1438);
            5:       coef = COEF_BITS'(872);
            8:       coef = COEF_BITS'(195);
            default: coef = '0;
        endcase
    endfunction

endpackage

/* rtl/core/gbg_front.sv */
// ----------------------------------------------------------------------------
// gbg_front
// Accepts RGB pixels, converts to gray, keeps the raster counters and the
// line store, and hands one column word per pixel to the queue.
// ----------------------------------------------------------------------------
module gbg_front
    import gbg_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_frame_cfg        i_cfg,
    input  logic              i_pix_valid,
    output logic              o_pix_ready,
    input  logic [PIX_W-1:0]  i_red,
    input  logic [PIX_W-1:0]  i_green,
    input  logic [PIX_W-1:0]  i_blue,
    input  t_q_status         i_q_stat,
    output logic              o_push,
    output t_qword            o_push_word
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  r_row;
    logic [LANE_W-1:0] r_lane;
    logic              r_s1_valid;

    logic [PIX_W-1:0]  r_s1_gray;
    logic [LANE_W-1:0] r_s1_lane;
    logic              r_s1_emit;
    logic [OCOL_W-1:0] r_s1_ccol;
    logic [OROW_W-1:0] r_s1_crow;
    logic              r_s1_last;
    t_col              r_rd;
    t_col              r_line_store [MAX_WIDTH];

    logic              s_acc;
    logic [CMP_W-1:0]  s_w;
    logic [CMP_W-1:0]  s_h;
    logic              s_last_col;
    logic              s_last_row;
    logic              s_emit;
    logic [CMP_W-1:0]  s_gray_sum;
    logic [PIX_W-1:0]  s_gray;
    logic [CW-1:0]     s_ccol;
    logic [ROW_W-1:0]  s_crow;

    always_comb begin
        if (i_cfg.width == '0) begin
            s_w = CMP_W'(1);
        end else if (CMP_W'(i_cfg.width) > CMP_W'(MAX_WIDTH)) begin
            s_w = CMP_W'(MAX_WIDTH);
        end else begin
            s_w = CMP_W'(i_cfg.width);
        end
        if (i_cfg.height == '0) begin
            s_h = CMP_W'(1);
        end else if (CMP_W'(i_cfg.height) > CMP_W'(MAX_ROWS)) begin
            s_h = CMP_W'(MAX_ROWS);
        end else begin
            s_h = CMP_W'(i_cfg.height);
        end
    end

    assign s_last_col = CMP_W'(r_col) >= (s_w - CMP_W'(1));
    assign s_last_row = CMP_W'(r_row) >= (s_h - CMP_W'(1));
    assign s_emit     = (r_col >= CW'(KERNEL_SIZE - 1)) && (r_row >= ROW_W'(KERNEL_SIZE - 1));
    assign s_ccol     = r_col - CW'(HALF_K);
    assign s_crow     = r_row - ROW_W'(HALF_K);

    assign s_gray_sum = CMP_W'(11) * CMP_W'(i_red) + CMP_W'(16) * CMP_W'(i_green)
                      + CMP_W'(5) * CMP_W'(i_blue);
    assign s_gray     = s_gray_sum[CMP_W-1:5];

    // Room is reserved for the word already held in the output stage, so a
    // word in that stage can always be pushed.
    assign o_pix_ready = ((QCNT_W + 1)'(i_q_stat.count) + (QCNT_W + 1)'(r_s1_valid))
                       < (QCNT_W + 1)'(Q_DEPTH);
    assign s_acc       = i_pix_valid && o_pix_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_lane     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= s_acc;
            if (s_acc) begin
                if (s_last_col) begin
                    r_col <= '0;
                    if (s_last_row) begin
                        r_row  <= '0;
                        r_lane <= '0;
                    end else begin
                        r_row  <= r_row + ROW_W'(1);
                        r_lane <= (r_lane == LANE_W'(KERNEL_SIZE - 1)) ? '0
                                                                        : r_lane + LANE_W'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // Line store: one lane per row slot, the read returns the word before
    // this pixel's write lands.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_line_store[r_col][r_lane] <= s_gray;
            r_rd                        <= r_line_store[r_col];
            r_s1_gray                   <= s_gray;
            r_s1_lane                   <= r_lane;
            r_s1_emit                   <= s_emit;
            r_s1_ccol                   <= OCOL_W'(s_ccol);
            r_s1_crow                   <= OROW_W'(s_crow);
            r_s1_last                   <= s_last_col && s_last_row;
        end
    end

    // Reorder the row slots so that entry 0 is the oldest row.
    always_comb begin
        logic [LANE_W:0] idx;
        o_push_word = '0;
        for (int di = 0; di < KERNEL_SIZE - 1; di++) begin
            idx = (LANE_W + 1)'(r_s1_lane) + (LANE_W + 1)'(di + 1);
            if (idx >= (LANE_W + 1)'(KERNEL_SIZE)) begin
                idx = idx - (LANE_W + 1)'(KERNEL_SIZE);
            end
            o_push_word.col[di] = r_rd[idx[LANE_W-1:0]];
        end
        o_push_word.col[KERNEL_SIZE-1] = r_s1_gray;
        o_push_word.emit = r_s1_emit;
        o_push_word.ccol = r_s1_ccol;
        o_push_word.crow = r_s1_crow;
        o_push_word.last = r_s1_last;
    end

    assign o_push = r_s1_valid;

endmodule

/* rtl/core/gbg_queue.sv */
// ----------------------------------------------------------------------------
// gbg_queue
// Short first-in first-out queue of column words between front and back.
// ----------------------------------------------------------------------------
module gbg_queue
    import gbg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_qword    i_push_word,
    input  logic      i_pop,
    output t_qword    o_head,
    output t_q_status o_stat
);

    t_qword            r_slot [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_word;
        end
    end

    assign o_head           = r_slot[r_rd_ptr];
    assign o_stat.not_empty = r_count != '0;
    assign o_stat.count     = r_count;

endmodule

/* rtl/core/gbg_back.sv */
// ----------------------------------------------------------------------------
// gbg_back
// Shifts column words into the 5x5 window, forms the weighted sum in two
// registered steps and holds the result in the output register.
// ----------------------------------------------------------------------------
module gbg_back
    import gbg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_qword            i_head,
    input  t_q_status         i_q_stat,
    output logic              o_pop,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [PIX_W-1:0]  o_gray_out,
    output logic [OCOL_W-1:0] o_center_column,
    output logic [OROW_W-1:0] o_center_row,
    output logic              o_frame_last
);

    localparam int HI_W = ACC_W - COEF_BITS;

    t_col              r_win [KERNEL_SIZE];
    logic              r_b1_valid;
    logic [OCOL_W-1:0] r_b1_ccol;
    logic [OROW_W-1:0] r_b1_crow;
    logic              r_b1_last;

    logic              r_b2_valid;
    logic [ACC_W-1:0]  r_b2_part [KERNEL_SIZE];
    logic [OCOL_W-1:0] r_b2_ccol;
    logic [OROW_W-1:0] r_b2_crow;
    logic              r_b2_last;

    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_gray;
    logic [OCOL_W-1:0] r_out_ccol;
    logic [OROW_W-1:0] r_out_crow;
    logic              r_out_last;

    logic              s_adv_out;
    logic              s_adv_b2;
    logic              s_adv_b1;
    logic              s_b1_to_b2;
    logic              s_b2_to_out;
    logic [ACC_W-1:0]  n_part [KERNEL_SIZE];
    logic [ACC_W-1:0]  s_sum;
    logic [HI_W-1:0]   s_hi;
    logic [PIX_W-1:0]  n_gray;

    assign s_adv_out   = !r_out_valid || i_res_ready;
    assign s_adv_b2    = !r_b2_valid || s_adv_out;
    assign s_adv_b1    = !r_b1_valid || s_adv_b2;
    assign s_b1_to_b2  = r_b1_valid && s_adv_b2;
    assign s_b2_to_out = r_b2_valid && s_adv_out;
    assign o_pop       = i_q_stat.not_empty && s_adv_b1;

    // Every word shifts the window; only words that complete an interior
    // window carry a result forward.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b1_valid <= i_head.emit;
            end else if (s_b1_to_b2) begin
                r_b1_valid <= 1'b0;
            end
            if (s_adv_b2) begin
                r_b2_valid <= r_b1_valid;
            end
            if (s_adv_out) begin
                r_out_valid <= r_b2_valid;
            end
        end
    end

    always_comb begin
        for (int di = 0; di < KERNEL_SIZE; di++) begin
            n_part[di] = '0;
            for (int dj = 0; dj < KERNEL_SIZE; dj++) begin
                n_part[di] = n_part[di] + ACC_W'(coef(di, dj)) * ACC_W'(r_win[dj][di]);
            end
        end
    end

    always_comb begin
        s_sum = '0;
        for (int di = 0; di < KERNEL_SIZE; di++) begin
            s_sum = s_sum + r_b2_part[di];
        end
        s_hi   = s_sum[ACC_W-1:COEF_BITS];
        n_gray = (s_hi > HI_W'(255)) ? PIX_W'(255) : s_hi[PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int dj = 0; dj < KERNEL_SIZE - 1; dj++) begin
                r_win[dj] <= r_win[dj+1];
            end
            r_win[KERNEL_SIZE-1] <= i_head.col;
            r_b1_ccol            <= i_head.ccol;
            r_b1_crow            <= i_head.crow;
            r_b1_last            <= i_head.last;
        end
        if (s_b1_to_b2) begin
            r_b2_part <= n_part;
            r_b2_ccol <= r_b1_ccol;
            r_b2_crow <= r_b1_crow;
            r_b2_last <= r_b1_last;
        end
        if (s_b2_to_out) begin
            r_out_gray <= n_gray;
            r_out_ccol <= r_b2_ccol;
            r_out_crow <= r_b2_crow;
            r_out_last <= r_b2_last;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_gray_out      = r_out_gray;
    assign o_center_column = r_out_ccol;
    assign o_center_row    = r_out_crow;
    assign o_frame_last    = r_out_last;

endmodule

/* rtl/core/gaussian_blur_5x5_gray.sv */
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_gray
// RGB raster stream to gray, 5x5 sigma-1 Gaussian blur of interior pixels.
//
//   Channel   Direction  Handshake                    Word
//   pixel     in         i_pix_valid / o_pix_ready    i_red, i_green, i_blue
//   result    out        o_res_valid / i_res_ready    gray, center column/row, last
//   config    in         i_cfg_wr_en (no wait)        i_cfg_index, i_cfg_data
//
// One pixel per clock sustained while i_res_ready stays high; a result goes
// through line store read, queue, window, row sums, final sum and clamp.
// Reset clears the raster counters and loads 640 x 480; the line store is not
// cleared, since every entry a window reads is written earlier in the frame.
// o_pix_ready falls when the words in the queue plus the word in the front
// output stage reach four, which happens only while i_res_ready stays low.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_gray
    import gbg_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_index,
    input  logic [CFGD_W-1:0] i_cfg_data,
    input  logic              i_pix_valid,
    output logic              o_pix_ready,
    input  logic [PIX_W-1:0]  i_red,
    input  logic [PIX_W-1:0]  i_green,
    input  logic [PIX_W-1:0]  i_blue,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [PIX_W-1:0]  o_gray_out,
    output logic [OCOL_W-1:0] o_center_column,
    output logic [OROW_W-1:0] o_center_row,
    output logic              o_frame_last
);

    t_frame_cfg r_cfg;
    logic       s_push;
    t_qword     s_push_word;
    logic       s_pop;
    t_qword     s_head;
    t_q_status  s_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= CFGW_W'(640);
            r_cfg.height <= CFGH_W'(480);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg.width  <= i_cfg_data[CFGW_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg.height <= i_cfg_data[CFGH_W-1:0];
                default:          r_cfg        <= r_cfg;
            endcase
        end
    end

    gbg_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pix_valid (i_pix_valid),
        .o_pix_ready (o_pix_ready),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_q_stat    (s_q_stat),
        .o_push      (s_push),
        .o_push_word (s_push_word)
    );

    gbg_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s_push),
        .i_push_word (s_push_word),
        .i_pop       (s_pop),
        .o_head      (s_head),
        .o_stat      (s_q_stat)
    );

    gbg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (s_head),
        .i_q_stat        (s_q_stat),
        .o_pop           (s_pop),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_gray_out      (o_gray_out),
        .o_center_column (o_center_column),
        .o_center_row    (o_center_row),
        .o_frame_last    (o_frame_last)
    );

    // The front must never push into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_push && !s_pop |-> s_q_stat.count < QCNT_W'(Q_DEPTH))
        else $error("queue overflow");

    // The back must never pop an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_pop |-> s_q_stat.not_empty)
        else $error("queue underflow");

    // An accepted pixel reaches the queue next cycle.
    a_push_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && o_pix_ready |=> s_push)
        else $error("accepted pixel not pushed");

    // Every result has its center at least two rows below the top and two columns in from the left.
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_center_row >= OROW_W'(HALF_K)) && (o_center_column >= OCOL_W'(HALF_K)))
        else $error("result outside interior");

endmodule

/* verif/gaussian_blur_5x5_gray_tb.sv */
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_gray_tb
// Streams RGB frames of many geometries through the 5x5 gray blur and checks
// every filtered word against a line-store model kept in the testbench.
// Power-on geometry, register writes in the middle of a frame, zero, too small
// and oversized dimensions are all covered, under changing handshake pressure.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_gray_tb;

    import gbg_pkg::*;

    localparam int LINE_MAX      = 1024;
    localparam int FRAME_ROWS    = 4096;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;

    typedef struct {
        logic [PIX_W-1:0]  gray;
        logic [OCOL_W-1:0] ccol;
        logic [OROW_W-1:0] crow;
        logic              last;
    } t_blur_word;

    // Gray conversion, line stores and window sums, mirrored word by word.
    class blur_predictor;
        logic [PIX_W-1:0] gray_lines [KERNEL_SIZE][LINE_MAX];
        int unsigned      weight_tab [KERNEL_SIZE][KERNEL_SIZE];
        int unsigned      col_pos;
        int unsigned      row_pos;
        int unsigned      width_reg;
        int unsigned      height_reg;
        t_blur_word       expected_blur_q[$];
        int               mismatches;

        function new();
            weight_tab = '{'{195,   872,  1438,   872,  195},
                           '{872,  3908,  6444,  3908,  872},
                           '{1438, 6444, 10624,  6444, 1438},
                           '{872,  3908,  6444,  3908,  872},
                           '{195,   872,  1438,   872,  195}};
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = 640;
            height_reg = 480;
            mismatches = 0;
        endfunction

        function void write_reg(logic index, logic [CFGD_W-1:0] value);
            if (index == CFG_IMAGE_WIDTH) width_reg = value[CFGW_W-1:0];
            else height_reg = value[CFGH_W-1:0];
        endfunction

        function void take_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                 logic [PIX_W-1:0] b);
            int unsigned w, h, c, rw, lum, acc, rr, cc;
            bit          end_col, end_row;
            t_blur_word  res;
            w = (width_reg == 0) ? 1 : ((width_reg > LINE_MAX) ? LINE_MAX : width_reg);
            h = (height_reg == 0) ? 1 : ((height_reg > FRAME_ROWS) ? FRAME_ROWS : height_reg);
            c   = col_pos % LINE_MAX;
            rw  = row_pos % FRAME_ROWS;
            lum = (11 * r + 16 * g + 5 * b) >> 5;
            end_col = (c >= w - 1);
            end_row = (rw >= h - 1);
            gray_lines[rw % KERNEL_SIZE][c] = PIX_W'(lum);

            if (c >= KERNEL_SIZE - 1 && rw >= KERNEL_SIZE - 1) begin
                acc = 0;
                for (int di = 0; di < KERNEL_SIZE; di++) begin
                    rr = (rw - (KERNEL_SIZE - 1) + di) % KERNEL_SIZE;
                    for (int dj = 0; dj < KERNEL_SIZE; dj++) begin
                        cc = c - (KERNEL_SIZE - 1) + dj;
                        acc += weight_tab[di][dj] * gray_lines[rr][cc];
                    end
                end
                acc = acc >> COEF_BITS;
                res.gray = (acc > 255) ? PIX_W'(255) : PIX_W'(acc);
                res.ccol = OCOL_W'(c - HALF_K);
                res.crow = OROW_W'(rw - HALF_K);
                res.last = end_col && end_row;
                expected_blur_q.push_back(res);
            end

            // A counter already past a freshly shrunk limit wraps at this step.
            if (end_col) begin
                col_pos = 0;
                row_pos = end_row ? 0 : rw + 1;
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function bit at_frame_start();
            return col_pos == 0 && row_pos == 0;
        endfunction

        function int pending();
            return expected_blur_q.size();
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_blur(t_blur_word got);
            t_blur_word want;
            if (expected_blur_q.size() == 0) begin
                report($sformatf("unexpected word gray=%0d col=%0d row=%0d last=%0d",
                                 got.gray, got.ccol, got.crow, got.last));
                return;
            end
            want = expected_blur_q.pop_front();
            if (got.gray !== want.gray)
                report($sformatf("gray %0d, want %0d at col %0d row %0d",
                                 got.gray, want.gray, want.ccol, want.crow));
            if (got.ccol !== want.ccol)
                report($sformatf("center column %0d, want %0d", got.ccol, want.ccol));
            if (got.crow !== want.crow)
                report($sformatf("center row %0d, want %0d", got.crow, want.crow));
            if (got.last !== want.last)
                report($sformatf("frame last %0d, want %0d at col %0d row %0d",
                                 got.last, want.last, want.ccol, want.crow));
        endtask
    endclass

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_cfg_wr_en     = 1'b0;
    logic              i_cfg_index     = CFG_IMAGE_WIDTH;
    logic [CFGD_W-1:0] i_cfg_data      = '0;
    logic              i_pix_valid     = 1'b0;
    logic [PIX_W-1:0]  i_red           = '0;
    logic [PIX_W-1:0]  i_green         = '0;
    logic [PIX_W-1:0]  i_blue          = '0;
    logic              i_res_ready     = 1'b0;
    logic              o_pix_ready;
    logic              o_res_valid;
    logic [PIX_W-1:0]  o_gray_out;
    logic [OCOL_W-1:0] o_center_column;
    logic [OROW_W-1:0] o_center_row;
    logic              o_frame_last;

    blur_predictor blur_model;
    int            snd_idle_pct  = 0;
    int            rcv_idle_pct  = 0;
    int            stall_cycles  = 0;

    gaussian_blur_5x5_gray #(
        .MAX_WIDTH(LINE_MAX)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pix_valid     (i_pix_valid),
        .o_pix_ready     (o_pix_ready),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_gray_out      (o_gray_out),
        .o_center_column (o_center_column),
        .o_center_row    (o_center_row),
        .o_frame_last    (o_frame_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: random back-pressure and checking of every accepted word.
    always @(posedge i_clk) begin
        t_blur_word got;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            got.gray = o_gray_out;
            got.ccol = o_center_column;
            got.crow = o_center_row;
            got.last = o_frame_last;
            blur_model.check_blur(got);
        end
        i_res_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_pix_valid && o_pix_ready) || (o_res_valid && i_res_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // Valid stays high from one word to the next unless a gap is drawn.
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_pix_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_pix_valid <= 1'b1;
        i_red       <= r;
        i_green     <= g;
        i_blue      <= b;
        do @(posedge i_clk); while (!o_pix_ready);
        blur_model.take_pixel(r, g, b);
    endtask

    task automatic send_random_pixel();
        send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                   PIX_W'($urandom_range(0, 255)));
    endtask

    // Some pixels produce no word, so the pipe may still be busy after the
    // last expected word; give it time before touching the registers.
    task automatic drain();
        i_pix_valid <= 1'b0;
        while (blur_model.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [CFGD_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        blur_model.write_reg(index, value);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // The width register is 11 bits; the spare data bits get random values.
    task automatic set_geometry(input int unsigned w, input int unsigned h);
        drain();
        write_reg(CFG_IMAGE_WIDTH, {2'($urandom_range(0, 3)), CFGW_W'(w)});
        write_reg(CFG_IMAGE_HEIGHT, CFGD_W'(h));
    endtask

    task automatic run_frames(input int unsigned w, input int unsigned h, input int n);
        set_geometry(w, h);
        repeat (n) begin
            do send_random_pixel(); while (!blur_model.at_frame_start());
        end
    endtask

    // Start a frame under one geometry, switch to another after n pixels and
    // finish the frame under the second one.
    task automatic run_cut_frame(input int unsigned w, input int unsigned h, input int n,
                                 input int unsigned w2, input int unsigned h2);
        set_geometry(w, h);
        repeat (n) send_random_pixel();
        set_geometry(w2, h2);
        do send_random_pixel(); while (!blur_model.at_frame_start());
    endtask

    // Mostly valid sizes, with an occasional frame too small to filter.
    task automatic random_frames(input int n);
        int unsigned w, h;
        repeat (n) begin
            w = ($urandom_range(0, 99) < 85) ? $urandom_range(5, 20) : $urandom_range(0, 4);
            h = ($urandom_range(0, 99) < 85) ? $urandom_range(5, 12) : $urandom_range(0, 4);
            run_frames(w, h, 1);
        end
    endtask

    initial begin
        int k;
        blur_model = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle_pct = 8;
        rcv_idle_pct = 48;

        // Power-on 640 x 480: the first twelve pixels of the top row, starting
        // with black, the pure primaries and white.
        for (k = 0; k < 12; k++) begin
            if (k == 0) send_pixel(8'd0, 8'd0, 8'd0);
            else if (k == 1) send_pixel(8'd255, 8'd0, 8'd0);
            else if (k == 2) send_pixel(8'd0, 8'd255, 8'd0);
            else if (k == 3) send_pixel(8'd0, 8'd0, 8'd255);
            else if (k == 4) send_pixel(8'd255, 8'd255, 8'd255);
            else send_random_pixel();
        end
        // Shrink the width mid-row: column 12 is already past it, so the next
        // pixel closes the top row. Then stop in row 6 and shrink the height,
        // which that row is already past, so the row closes the frame.
        set_geometry(8, 8);
        repeat (1 + 5 * 8 + 3) send_random_pixel();
        set_geometry(8, 5);
        do send_random_pixel(); while (!blur_model.at_frame_start());

        run_frames(8, 6, 1);
        run_frames(5, 5, 2);
        run_frames(0, 7, 1);
        run_frames(12, 0, 1);
        run_frames(4, 9, 1);
        run_frames(9, 4, 1);
        random_frames(1);

        snd_idle_pct = 48;
        rcv_idle_pct = 8;
        // An oversized width, cut short by a narrower one in the top row.
        run_cut_frame(2047, 5, 20, 14, 5);
        random_frames(1);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        // An oversized height, cut short in row 6 by a height of six.
        run_cut_frame(6, 8191, 40, 6, 6);
        random_frames(2);

        drain();
        if (blur_model.mismatches == 0 && blur_model.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
